@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file msd_checker.sv
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, disabled while reset is held
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// concurrent assertion that also checks behavior around reset
`define ASSERT_CLK_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/msd_pkg.sv @@
// types and constants for the modrm/sib operand decoder
// no dependencies; used by msd_decode and the top level
package msd_pkg;

    // modrm mod field
    localparam logic [1:0] MOD_NODISP = 2'b00;
    localparam logic [1:0] MOD_DISP8  = 2'b01;
    localparam logic [1:0] MOD_DISP32 = 2'b10;
    localparam logic [1:0] MOD_REG    = 2'b11;

    // rm / sib field codes
    localparam logic [2:0] RM_SIB     = 3'b100;
    localparam logic [2:0] RM_DISP32  = 3'b101;
    localparam logic [2:0] IDX_NONE   = 3'b100;

    // displacement sizes in bytes
    localparam logic [2:0] DISP_NONE  = 3'd0;
    localparam logic [2:0] DISP_LEN8  = 3'd1;
    localparam logic [2:0] DISP_LEN32 = 3'd4;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 48;

    typedef enum logic [1:0] {
        PH_MODRM = 2'd0,
        PH_SIB   = 2'd1,
        PH_DISP  = 2'd2
    } msd_phase_t;

    typedef struct packed {
        logic        register_direct;
        logic [2:0]  base_reg;
        logic        base_present;
        logic [2:0]  index_reg;
        logic        index_present;
        logic [1:0]  scale_shift;
        logic [31:0] displacement;
        logic        constant_address;
        logic [2:0]  operand_length;
    } msd_result_t;

endpackage

@@ rtl/x86_modrm_sib_operand_decoder_unit.sv @@
// x86 32-bit modrm/sib memory operand decoder, stream top level
// depends on msd_pkg and msd_decode
//
// Instruction bytes enter on the s_ side, one byte per transaction, and the
// decoder takes a byte in every cycle that s_tready is high. s_tuser high
// marks a modrm byte and restarts decode; an optional sib byte and an 8- or
// 32-bit displacement follow. When the operand is complete, including a
// register-direct modrm, one result is registered and leaves on the m_ side.
// Results go through a two-entry output buffer, so input flows on while a
// result waits, and s_tready drops only when both entries are full.
module x86_modrm_sib_operand_decoder_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [msd_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] code_byte
    input  logic                            s_tuser,   // [0] start_req
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] base_reg, [3] base_present, [6:4] index_reg, [7] index_present,
    // [9:8] scale_shift, [41:10] displacement, [42] constant_address,
    // [45:43] operand_length, [47:46] zero
    output logic [msd_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tuser    // [0] register_direct
);

    logic                 accept;
    logic                 take;
    logic                 emit;
    msd_pkg::msd_result_t result;

    logic                 out_valid_reg, out_valid_next;
    msd_pkg::msd_result_t out_data_reg, out_data_next;
    logic                 skid_valid_reg, skid_valid_next;
    msd_pkg::msd_result_t skid_data_reg, skid_data_next;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign take     = out_valid_reg && m_tready;

    msd_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (accept),
        .code_byte (s_tdata[7:0]),
        .start_req (s_tuser),
        .emit      (emit),
        .result    (result)
    );

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (take) begin
            if (skid_valid_reg) begin
                // no new result can arrive while the skid entry is full
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = accept && emit;
                out_data_next  = result;
            end
        end else if (accept && emit) begin
            if (!out_valid_reg) begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg.register_direct;
    assign m_tdata  = {2'b00,
                       out_data_reg.operand_length,
                       out_data_reg.constant_address,
                       out_data_reg.displacement,
                       out_data_reg.scale_shift,
                       out_data_reg.index_present,
                       out_data_reg.index_reg,
                       out_data_reg.base_present,
                       out_data_reg.base_reg};

endmodule

@@ rtl/msd_decode.sv @@
// operand decode state machine: one instruction byte per accepted transaction
// depends on msd_pkg
module msd_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic [7:0]          code_byte,
    input  logic                start_req,
    output logic                emit,
    output msd_pkg::msd_result_t result
);

    msd_pkg::msd_phase_t phase_reg, phase_next;
    logic [1:0]  mode_bits_reg, mode_bits_next;
    logic [2:0]  base_field_reg, base_field_next;
    logic        base_flag_reg, base_flag_next;
    logic [2:0]  index_field_reg, index_field_next;
    logic        index_flag_reg, index_flag_next;
    logic [1:0]  scale_field_reg, scale_field_next;
    logic [31:0] disp_accum_reg, disp_accum_next;
    logic [2:0]  disp_left_reg, disp_left_next;
    logic [2:0]  disp_total_reg, disp_total_next;
    logic [2:0]  bytes_seen_reg, bytes_seen_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= msd_pkg::PH_MODRM;
            mode_bits_reg   <= '0;
            base_field_reg  <= '0;
            base_flag_reg   <= 1'b0;
            index_field_reg <= '0;
            index_flag_reg  <= 1'b0;
            scale_field_reg <= '0;
            disp_accum_reg  <= '0;
            disp_left_reg   <= '0;
            disp_total_reg  <= '0;
            bytes_seen_reg  <= '0;
        end else if (advance) begin
            phase_reg       <= phase_next;
            mode_bits_reg   <= mode_bits_next;
            base_field_reg  <= base_field_next;
            base_flag_reg   <= base_flag_next;
            index_field_reg <= index_field_next;
            index_flag_reg  <= index_flag_next;
            scale_field_reg <= scale_field_next;
            disp_accum_reg  <= disp_accum_next;
            disp_left_reg   <= disp_left_next;
            disp_total_reg  <= disp_total_next;
            bytes_seen_reg  <= bytes_seen_next;
        end
    end

    always_comb begin
        logic [2:0] low3;
        logic       plan;
        logic       no_base_disp32;
        logic       direct;
        logic [1:0] pos;

        low3             = code_byte[2:0];
        plan             = 1'b0;
        no_base_disp32   = 1'b0;
        direct           = 1'b0;
        pos              = 2'(disp_total_reg - disp_left_reg);
        emit             = 1'b0;

        phase_next       = phase_reg;
        mode_bits_next   = mode_bits_reg;
        base_field_next  = base_field_reg;
        base_flag_next   = base_flag_reg;
        index_field_next = index_field_reg;
        index_flag_next  = index_flag_reg;
        scale_field_next = scale_field_reg;
        disp_accum_next  = disp_accum_reg;
        disp_left_next   = disp_left_reg;
        disp_total_next  = disp_total_reg;
        bytes_seen_next  = bytes_seen_reg;

        if (start_req) begin
            // a start byte always restarts, whatever was in progress
            mode_bits_next   = code_byte[7:6];
            bytes_seen_next  = 3'd1;
            index_field_next = '0;
            index_flag_next  = 1'b0;
            scale_field_next = '0;
            disp_accum_next  = '0;
            disp_total_next  = msd_pkg::DISP_NONE;
            disp_left_next   = msd_pkg::DISP_NONE;
            if (code_byte[7:6] == msd_pkg::MOD_REG) begin
                base_field_next = low3;
                base_flag_next  = 1'b1;
                direct          = 1'b1;
                emit            = 1'b1;
                phase_next      = msd_pkg::PH_MODRM;
            end else if (low3 == msd_pkg::RM_SIB) begin
                base_field_next = '0;
                base_flag_next  = 1'b0;
                phase_next      = msd_pkg::PH_SIB;
            end else if (code_byte[7:6] == msd_pkg::MOD_NODISP &&
                         low3 == msd_pkg::RM_DISP32) begin
                base_field_next = '0;
                base_flag_next  = 1'b0;
                plan            = 1'b1;
                no_base_disp32  = 1'b1;
            end else begin
                base_field_next = low3;
                base_flag_next  = 1'b1;
                plan            = 1'b1;
            end
        end else begin
            unique case (phase_reg)
                msd_pkg::PH_SIB: begin
                    bytes_seen_next  = 3'(bytes_seen_reg + 3'd1);
                    scale_field_next = code_byte[7:6];
                    index_field_next = code_byte[5:3];
                    index_flag_next  = (code_byte[5:3] != msd_pkg::IDX_NONE);
                    plan             = 1'b1;
                    if (low3 == msd_pkg::RM_DISP32 &&
                        mode_bits_reg == msd_pkg::MOD_NODISP) begin
                        base_field_next = '0;
                        base_flag_next  = 1'b0;
                        no_base_disp32  = 1'b1;
                    end else begin
                        base_field_next = low3;
                        base_flag_next  = 1'b1;
                    end
                end
                msd_pkg::PH_DISP: begin
                    // little-endian byte placement
                    disp_accum_next = disp_accum_reg |
                                      (32'(code_byte) << {pos, 3'b000});
                    if (disp_left_reg != 3'd0) begin
                        disp_left_next = 3'(disp_left_reg - 3'd1);
                    end
                    bytes_seen_next = 3'(bytes_seen_reg + 3'd1);
                    if (disp_left_reg <= 3'd1) begin
                        emit       = 1'b1;
                        phase_next = msd_pkg::PH_MODRM;
                    end
                end
                default: begin
                    // idle byte while waiting for modrm
                end
            endcase
        end

        if (plan) begin
            if (no_base_disp32 || mode_bits_next == msd_pkg::MOD_DISP32) begin
                disp_total_next = msd_pkg::DISP_LEN32;
            end else if (mode_bits_next == msd_pkg::MOD_DISP8) begin
                disp_total_next = msd_pkg::DISP_LEN8;
            end else begin
                disp_total_next = msd_pkg::DISP_NONE;
            end
            disp_left_next  = disp_total_next;
            disp_accum_next = '0;
            if (disp_total_next == msd_pkg::DISP_NONE) begin
                emit       = 1'b1;
                phase_next = msd_pkg::PH_MODRM;
            end else begin
                phase_next = msd_pkg::PH_DISP;
            end
        end

        result.register_direct  = direct;
        result.base_reg         = base_flag_next ? base_field_next : 3'd0;
        result.base_present     = base_flag_next;
        result.index_reg        = index_flag_next ? index_field_next : 3'd0;
        result.index_present    = index_flag_next;
        result.scale_shift      = scale_field_next;
        result.displacement     = (disp_total_next == msd_pkg::DISP_LEN8 &&
                                   disp_accum_next[7]) ?
                                  {24'hFF_FFFF, disp_accum_next[7:0]} :
                                  disp_accum_next;
        result.constant_address = !direct && !base_flag_next && !index_flag_next;
        result.operand_length   = bytes_seen_next;
    end

endmodule

@@ rtl/msd_checker.sv @@
// port-level checks for the operand decoder, bound to the top level
// depends on assert_macros.svh and msd_pkg
`include "assert_macros.svh"

module msd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [msd_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);

    // a stalled result keeps its contents
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // input back-pressure only when the output side is holding a result
    `ASSERT_CLK(a_bp_needs_out, aclk, aresetn, s_tvalid && !s_tready |-> m_tvalid, "input stalled with empty output")

    // register-direct results are one byte long with a register base only
    `ASSERT_CLK(a_direct_form, aclk, aresetn, m_tvalid && m_tuser |-> m_tdata[45:43] == 3'd1 && m_tdata[3] && !m_tdata[7] && !m_tdata[42] && m_tdata[41:10] == 32'd0, "bad register-direct result")

    // constant address exactly when a memory operand has no base and no index
    `ASSERT_CLK(a_const_addr, aclk, aresetn, m_tvalid && !m_tuser |-> m_tdata[42] == !(m_tdata[3] || m_tdata[7]), "constant address flag mismatch")

    // reset empties the output buffer
    `ASSERT_CLK_RST(a_reset_empty, aclk, !aresetn |=> !m_tvalid && s_tready, "buffer not empty after reset")

endmodule

bind x86_modrm_sib_operand_decoder_unit msd_checker u_msd_checker (.*);

@@ tb/sv/modrm_operand_checker.sv @@
// checker for the modrm/sib operand decoder: watches both stream channels,
// predicts each decoded operand and compares it field by field
// depends on msd_pkg
module modrm_operand_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [msd_pkg::S_TDATA_W-1:0]   s_tdata,    // [7:0] code_byte
    input  logic                            s_tuser,    // [0] start_req
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] base_reg, [3] base_present, [6:4] index_reg, [7] index_present,
    // [9:8] scale_shift, [41:10] displacement, [42] constant_address,
    // [45:43] operand_length, [47:46] zero
    input  logic [msd_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            m_tuser,    // [0] register_direct
    output int                              mismatch_count,
    output int                              pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // decoder state as the predictor tracks it
    msd_pkg::msd_phase_t dec_phase;
    logic [1:0]  mod_q;
    logic [2:0]  base_q;
    logic        base_en;
    logic [2:0]  idx_q;
    logic        idx_en;
    logic [1:0]  scale_q;
    logic [31:0] disp_q;
    logic [2:0]  disp_left;
    logic [2:0]  disp_len;
    logic [2:0]  len_q;

    msd_pkg::msd_result_t expected_operands [$];
    msd_pkg::msd_result_t want;
    int          fail_total = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("%0t ns: mismatch on %0s: got 0x%0h, expected 0x%0h",
                 $time, what, got, exp_val);
        fail_total++;
    endtask

    task automatic close_operand(input logic direct);
        msd_pkg::msd_result_t r;
        logic [31:0] d;
        d = disp_q;
        if (disp_len == msd_pkg::DISP_LEN8 && d[7]) begin
            d[31:8] = '1;
        end
        r.register_direct  = direct;
        r.base_reg         = base_en ? base_q : 3'd0;
        r.base_present     = base_en;
        r.index_reg        = idx_en ? idx_q : 3'd0;
        r.index_present    = idx_en;
        r.scale_shift      = scale_q;
        r.displacement     = d;
        r.constant_address = !direct && !base_en && !idx_en;
        r.operand_length   = len_q;
        expected_operands.push_back(r);
        dec_phase = msd_pkg::PH_MODRM;
    endtask

    // size the displacement from mod; with none the operand is done
    task automatic open_displacement(input logic no_base);
        if (no_base || mod_q == msd_pkg::MOD_DISP32) begin
            disp_len = msd_pkg::DISP_LEN32;
        end else if (mod_q == msd_pkg::MOD_DISP8) begin
            disp_len = msd_pkg::DISP_LEN8;
        end else begin
            disp_len = msd_pkg::DISP_NONE;
        end
        disp_left = disp_len;
        disp_q    = '0;
        if (disp_len == msd_pkg::DISP_NONE) begin
            close_operand(1'b0);
        end else begin
            dec_phase = msd_pkg::PH_DISP;
        end
    endtask

    task automatic advance_decode(input logic [7:0] b, input logic start);
        logic [1:0] pos;
        if (start) begin
            mod_q     = b[7:6];
            len_q     = 3'd1;
            idx_q     = '0;
            idx_en    = 1'b0;
            scale_q   = '0;
            disp_q    = '0;
            disp_len  = msd_pkg::DISP_NONE;
            disp_left = msd_pkg::DISP_NONE;
            if (mod_q == msd_pkg::MOD_REG) begin
                base_q  = b[2:0];
                base_en = 1'b1;
                close_operand(1'b1);
            end else if (b[2:0] == msd_pkg::RM_SIB) begin
                base_q    = '0;
                base_en   = 1'b0;
                dec_phase = msd_pkg::PH_SIB;
            end else if (mod_q == msd_pkg::MOD_NODISP && b[2:0] == msd_pkg::RM_DISP32) begin
                base_q  = '0;
                base_en = 1'b0;
                open_displacement(1'b1);
            end else begin
                base_q  = b[2:0];
                base_en = 1'b1;
                open_displacement(1'b0);
            end
        end else if (dec_phase == msd_pkg::PH_SIB) begin
            len_q   = len_q + 3'd1;
            scale_q = b[7:6];
            idx_q   = b[5:3];
            idx_en  = (b[5:3] != msd_pkg::IDX_NONE);
            if (b[2:0] == msd_pkg::RM_DISP32 && mod_q == msd_pkg::MOD_NODISP) begin
                base_q  = '0;
                base_en = 1'b0;
                open_displacement(1'b1);
            end else begin
                base_q  = b[2:0];
                base_en = 1'b1;
                open_displacement(1'b0);
            end
        end else if (dec_phase == msd_pkg::PH_DISP) begin
            // little-endian: byte position is how many have arrived already
            pos = 2'(disp_len - disp_left);
            disp_q = disp_q | (32'(b) << (8 * pos));
            if (disp_left != 0) begin
                disp_left = disp_left - 3'd1;
            end
            len_q = len_q + 3'd1;
            if (disp_left == 0) begin
                close_operand(1'b0);
            end
        end
        // a non-start byte while waiting for modrm is dropped
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            dec_phase = msd_pkg::PH_MODRM;
            mod_q     = '0;
            base_q    = '0;
            base_en   = 1'b0;
            idx_q     = '0;
            idx_en    = 1'b0;
            scale_q   = '0;
            disp_q    = '0;
            disp_left = '0;
            disp_len  = '0;
            len_q     = '0;
            expected_operands.delete();
        end else begin
            // input first, then output; a result is registered, so it never leaves in the cycle of its byte
            if (s_tvalid && s_tready) begin
                advance_decode(s_tdata[7:0], s_tuser);
            end
            if (m_tvalid && m_tready) begin
                if (expected_operands.size() == 0) begin
                    report_mismatch("result with nothing expected", m_tdata[31:0], '0);
                end else begin
                    want = expected_operands.pop_front();
                    if (m_tuser !== want.register_direct)
                        report_mismatch("register_direct", 32'(m_tuser),
                                        32'(want.register_direct));
                    if (m_tdata[2:0] !== want.base_reg)
                        report_mismatch("base_reg", 32'(m_tdata[2:0]), 32'(want.base_reg));
                    if (m_tdata[3] !== want.base_present)
                        report_mismatch("base_present", 32'(m_tdata[3]),
                                        32'(want.base_present));
                    if (m_tdata[6:4] !== want.index_reg)
                        report_mismatch("index_reg", 32'(m_tdata[6:4]), 32'(want.index_reg));
                    if (m_tdata[7] !== want.index_present)
                        report_mismatch("index_present", 32'(m_tdata[7]),
                                        32'(want.index_present));
                    if (m_tdata[9:8] !== want.scale_shift)
                        report_mismatch("scale_shift", 32'(m_tdata[9:8]),
                                        32'(want.scale_shift));
                    if (m_tdata[41:10] !== want.displacement)
                        report_mismatch("displacement", m_tdata[41:10], want.displacement);
                    if (m_tdata[42] !== want.constant_address)
                        report_mismatch("constant_address", 32'(m_tdata[42]),
                                        32'(want.constant_address));
                    if (m_tdata[45:43] !== want.operand_length)
                        report_mismatch("operand_length", 32'(m_tdata[45:43]),
                                        32'(want.operand_length));
                    if (m_tdata[47:46] !== 2'b00)
                        report_mismatch("tdata padding", 32'(m_tdata[47:46]), '0);
                end
            end
        end
        mismatch_count <= fail_total;
        pending_count  <= expected_operands.size();
    end

endmodule

@@ tb/sv/tb_x86_modrm_sib_operand_decoder_unit.sv @@
// testbench top for the modrm/sib operand decoder: clock, reset, byte stimulus,
// result-side back-pressure and the verdict
// depends on msd_pkg, the decoder rtl and modrm_operand_checker
module tb_x86_modrm_sib_operand_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TARGET_BYTES = 550;
    localparam int CALM_BYTES   = 460;   // no idling past this point
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 80;

    logic                           aclk;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [msd_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic                           s_tuser  = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [msd_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           m_tuser;

    int   mismatch_count;
    int   pending_count;
    logic idle_on = 1'b1;
    int   bytes_sent = 0;
    int   cycle_count = 0;

    x86_modrm_sib_operand_decoder_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    modrm_operand_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // one byte per transaction, with an occasional idle burst ahead of it
    task automatic send_byte(input logic [7:0] b, input logic start);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // sends a well-formed operand; cut > 0 stops early so the next start restarts
    task automatic send_operand(input logic [7:0] modrm, input logic [7:0] sib,
                                input logic [31:0] disp, input int cut);
        logic [7:0] seq [$];
        int disp_n;
        int n;
        seq.push_back(modrm);
        disp_n = 0;
        if (modrm[7:6] != msd_pkg::MOD_REG) begin
            if (modrm[2:0] == msd_pkg::RM_SIB) seq.push_back(sib);
            if (modrm[7:6] == msd_pkg::MOD_DISP32) begin
                disp_n = 4;
            end else if (modrm[7:6] == msd_pkg::MOD_DISP8) begin
                disp_n = 1;
            end else if (modrm[2:0] == msd_pkg::RM_DISP32 ||
                         (modrm[2:0] == msd_pkg::RM_SIB &&
                          sib[2:0] == msd_pkg::RM_DISP32)) begin
                disp_n = 4;
            end
        end
        for (int i = 0; i < disp_n; i++) seq.push_back(disp[8*i +: 8]);
        n = (cut > 0 && cut < seq.size()) ? cut : seq.size();
        for (int i = 0; i < n; i++) begin
            send_byte(seq[i], i == 0);
            bytes_sent++;
        end
    endtask

    task automatic wait_results_drained();
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    // result side: random stalls plus one long hold-off to fill the output buffer
    initial begin
        int  results_taken;
        logic long_hold_done;
        results_taken  = 0;
        long_hold_done = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) results_taken++;
            if (results_taken >= 40 && !long_hold_done) begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("x86_modrm_sib_operand_decoder_unit test failed");
        $finish;
    end

    initial begin
        logic [7:0]  modrm;
        logic [7:0]  sib;
        logic [31:0] disp;
        int          pick;
        logic        paused_mid;
        logic        cut_open;
        paused_mid = 1'b0;
        cut_open   = 1'b0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: register-direct, plain base, disp32 only, disp8 sign edges,
        // disp32 extremes, sib without index, sib with no base, sib with disp8
        send_operand(8'hC0, 8'h00, 32'h0, 0);
        send_operand(8'hFF, 8'h00, 32'h0, 0);
        send_operand(8'h00, 8'h00, 32'h0, 0);
        send_operand(8'h05, 8'h00, 32'hFFFF_FFFF, 0);
        send_operand(8'h43, 8'h00, 32'h80, 0);
        send_operand(8'h47, 8'h00, 32'h7F, 0);
        send_operand(8'h87, 8'h00, 32'h8000_0000, 0);
        send_operand(8'h04, 8'h20, 32'h0, 0);
        send_operand(8'h04, 8'hE5, 32'h7FFF_FFFF, 0);
        send_operand(8'h44, 8'h6D, 32'hF0, 0);
        // stray byte while waiting for modrm is ignored
        send_byte(8'hFF, 1'b0);
        // restarts in the sib phase and in the middle of a displacement
        send_operand(8'h84, 8'h00, 32'h0, 2);
        send_operand(8'h80, 8'h00, 32'h11, 3);
        send_operand(8'h44, 8'h25, 32'h80, 1);
        send_operand(8'hC5, 8'h00, 32'h0, 0);

        s_tvalid <= 1'b0;
        wait_results_drained();

        while (bytes_sent < TARGET_BYTES) begin
            if (bytes_sent >= CALM_BYTES && idle_on) idle_on <= 1'b0;
            if (!paused_mid && bytes_sent >= TARGET_BYTES / 2) begin
                paused_mid = 1'b1;
                s_tvalid <= 1'b0;
                wait_results_drained();
            end
            modrm = 8'($urandom_range(0, 255));
            sib   = 8'($urandom_range(0, 255));
            disp  = $urandom();
            pick  = $urandom_range(0, 99);
            if (pick < 6 && !cut_open) begin
                send_byte(8'($urandom_range(0, 255)), 1'b0);
            end else if (pick < 18) begin
                send_operand(modrm, sib, disp, $urandom_range(1, 5));
                cut_open = 1'b1;
            end else begin
                send_operand(modrm, sib, disp, 0);
                cut_open = 1'b0;
            end
        end

        s_tvalid <= 1'b0;
        wait_results_drained();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("x86_modrm_sib_operand_decoder_unit test passed");
        end else begin
            $display("x86_modrm_sib_operand_decoder_unit test failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/msd_pkg.sv
rtl/msd_decode.sv
rtl/x86_modrm_sib_operand_decoder_unit.sv
rtl/msd_checker.sv
tb/sv/modrm_operand_checker.sv
tb/sv/tb_x86_modrm_sib_operand_decoder_unit.sv
